// ===== src/step_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Step counter assertion macros
// Concurrent checks on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEP_COUNTER_ASSERT_SVH
`define STEP_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// a must bring b in the same cycle
`define STC_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("step_counter check failed");

// a must bring b in the next cycle
`define STC_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("step_counter check failed");

`else

`define STC_ASSERT_IMP(label, a, b)
`define STC_ASSERT_NXT(label, a, b)

`endif

`endif

// ===== src/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// Step counter package
// Widths, register indexes, reset values and shared record types.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TOTAL_BITS  = 24;
    localparam int BASE_BITS   = SAMPLE_BITS + 16;
    localparam int PROD_BITS   = BASE_BITS + 16;
    localparam int CMP_BITS    = (BASE_BITS > 32) ? BASE_BITS : 32;

    localparam int MAG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int OTOT_W  = 24;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_STEP_THRESHOLD  = 3'd0;
    localparam t_cfg_idx CFG_BASELINE_ALPHA  = 3'd1;
    localparam t_cfg_idx CFG_MIN_INTERVAL_MS = 3'd2;
    localparam t_cfg_idx CFG_MAX_INTERVAL_MS = 3'd3;
    localparam t_cfg_idx CFG_RUN_TO_COUNT    = 3'd4;

    localparam logic [15:0]      RST_STEP_THRESHOLD  = 16'd1024;
    localparam logic [15:0]      RST_BASELINE_ALPHA  = 16'd3277;
    localparam logic [15:0]      RST_MIN_INTERVAL_MS = 16'd250;
    localparam logic [15:0]      RST_MAX_INTERVAL_MS = 16'd2000;
    localparam logic [CNT_W-1:0] RST_RUN_TO_COUNT    = 4'd4;

    typedef struct packed {
        logic [15:0]      step_threshold;
        logic [15:0]      baseline_alpha;
        logic [15:0]      min_interval_ms;
        logic [15:0]      max_interval_ms;
        logic [CNT_W-1:0] run_to_count;
    } t_cfg;

    typedef struct packed {
        logic [BASE_BITS-1:0]  baseline;
        logic                  armed;
        logic [CNT_W-1:0]      run_length;
        logic [TIME_W-1:0]     last_step_time;
        logic [TOTAL_BITS-1:0] step_total;
    } t_state;

    typedef struct packed {
        logic [OTOT_W-1:0] total_steps;
        logic [CNT_W-1:0]  steps_added;
        logic              peak_seen;
    } t_result;

endpackage

// ===== src/stc_if.sv =====
// ----------------------------------------------------------------------------
// Step counter channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MAG_W-1:0]  magnitude;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output magnitude, output now_ms, input ready);
    modport sink   (input valid, input magnitude, input now_ms, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OTOT_W-1:0] total_steps;
    logic [CNT_W-1:0]  steps_added;
    logic              peak_seen;

    modport source (output valid, output total_steps, output steps_added,
                    output peak_seen, input ready);
    modport sink   (input valid, input total_steps, input steps_added,
                    input peak_seen, output ready);
endinterface

interface stc_cfg_if import stc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/stc_update.sv =====
// ----------------------------------------------------------------------------
// Step counter update
// Baseline filter, peak detection and run bookkeeping for one sample.
// ----------------------------------------------------------------------------
module stc_update import stc_pkg::*; (
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [MAG_W-1:0]  i_magnitude,
    input  logic [TIME_W-1:0] i_now_ms,
    output t_state            o_state,
    output t_result           o_result
);

    logic [SAMPLE_BITS-1:0]  mag;
    logic [BASE_BITS-1:0]    target;
    logic                    negative;
    logic [BASE_BITS-1:0]    exc;
    logic [PROD_BITS-1:0]    prod;
    logic [PROD_BITS-1:0]    rounded;
    logic [BASE_BITS-1:0]    delta;
    logic                    reached;
    logic [TIME_W-1:0]       elapsed;
    logic                    dropped;
    logic [CNT_W-1:0]        run0;
    logic [CNT_W-1:0]        run1;
    logic [CNT_W-1:0]        added;
    logic [TOTAL_BITS:0]     sum;

    always_comb begin
        mag      = SAMPLE_BITS'(i_magnitude);
        target   = {mag, 16'h0000};
        negative = target < i_state.baseline;
        exc      = negative ? (i_state.baseline - target) : (target - i_state.baseline);
        prod     = PROD_BITS'(exc) * PROD_BITS'(i_cfg.baseline_alpha);
        rounded  = prod + (negative ? PROD_BITS'(16'hFFFF) : '0);
        delta    = BASE_BITS'(rounded >> 16);
        reached  = !negative &&
                   (CMP_BITS'(exc) >= CMP_BITS'({i_cfg.step_threshold, 16'h0000}));
        elapsed  = i_now_ms - i_state.last_step_time;

        o_state  = i_state;
        o_state.baseline = negative ? (i_state.baseline - delta) : (i_state.baseline + delta);

        added   = '0;
        dropped = 1'b0;
        run0    = i_state.run_length;
        run1    = i_state.run_length;
        o_result.peak_seen = 1'b0;

        if (!i_state.armed) begin
            if (negative) begin
                o_state.armed = 1'b1;
            end
        end else if (reached) begin
            o_state.armed      = 1'b0;
            o_result.peak_seen = 1'b1;
            dropped = (i_state.run_length != '0) &&
                      (elapsed < TIME_W'(i_cfg.min_interval_ms));
            if (!dropped) begin
                if ((i_state.run_length != '0) &&
                    (elapsed >= TIME_W'(i_cfg.max_interval_ms))) begin
                    run0 = '0;
                end
                o_state.last_step_time = i_now_ms;
                o_state.run_length     = run0;
                if (run0 < i_cfg.run_to_count) begin
                    run1 = run0 + 1'b1;
                    o_state.run_length = run1;
                    if (run1 == i_cfg.run_to_count) begin
                        added = i_cfg.run_to_count;
                    end
                end else begin
                    added = CNT_W'(1);
                end
            end
        end

        sum = (TOTAL_BITS+1)'(i_state.step_total) + (TOTAL_BITS+1)'(added);
        o_state.step_total = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];

        o_result.total_steps = OTOT_W'(o_state.step_total);
        o_result.steps_added = added;
    end

endmodule

// ===== src/step_counter.sv =====
// ----------------------------------------------------------------------------
// Step counter
// Pedometer step detection on an acceleration magnitude stream.
// ----------------------------------------------------------------------------
// A sample passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the 32x16 baseline multiply sits in one stage.
// An input register parts the sides, so a sample is taken while a result waits.
// Reset (synchronous, active low) clears the filter, run and total state and
// loads the register defaults; no clearing pass.
module step_counter import stc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    stc_cfg_if.sink   i_cfg,
    stc_in_if.sink    i_in,
    stc_out_if.source o_out
);

    `include "step_counter_assert.svh"

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;
    t_result           r_result;
    logic              r_in_valid;
    logic [MAG_W-1:0]  r_mag;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.total_steps = r_result.total_steps;
    assign o_out.steps_added = r_result.steps_added;
    assign o_out.peak_seen   = r_result.peak_seen;

    stc_update u_update (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_magnitude (r_mag),
        .i_now_ms    (r_now),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_threshold  <= RST_STEP_THRESHOLD;
            r_cfg.baseline_alpha  <= RST_BASELINE_ALPHA;
            r_cfg.min_interval_ms <= RST_MIN_INTERVAL_MS;
            r_cfg.max_interval_ms <= RST_MAX_INTERVAL_MS;
            r_cfg.run_to_count    <= RST_RUN_TO_COUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STEP_THRESHOLD:  r_cfg.step_threshold  <= i_cfg.data;
                CFG_BASELINE_ALPHA:  r_cfg.baseline_alpha  <= i_cfg.data;
                CFG_MIN_INTERVAL_MS: r_cfg.min_interval_ms <= i_cfg.data;
                CFG_MAX_INTERVAL_MS: r_cfg.max_interval_ms <= i_cfg.data;
                CFG_RUN_TO_COUNT:    r_cfg.run_to_count    <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mag <= i_in.magnitude;
            r_now <= i_in.now_ms;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    `STC_ASSERT_IMP(a_added_needs_peak, r_out_valid && (r_result.steps_added != '0),
                    r_result.peak_seen)
    `STC_ASSERT_NXT(a_advance_fills_out, advance, r_out_valid)
    `STC_ASSERT_NXT(a_stall_holds_out, r_out_valid && !o_out.ready && !advance, r_out_valid)
    `STC_ASSERT_IMP(a_total_monotonic, $past(i_rst_n),
                    r_state.step_total >= $past(r_state.step_total))

endmodule
